[rtl/core/assert_macros.svh]
// Assertion macros shared by the watchdog servicer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent check that is switched off while reset is asserted.
`define QAWS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define QAWS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define QAWS_ASSERT(lbl, clk, rst_n, prop, msg)
`define QAWS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/core/qaws_pkg.sv]
// Shared types and constants of the watchdog servicer.
package qaws_pkg;

  localparam int COUNT_WIDTH     = 32;
  localparam int RT_WIDTH        = 32;
  localparam int CMP_WIDTH       = (COUNT_WIDTH > RT_WIDTH) ? COUNT_WIDTH : RT_WIDTH;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int TARGET_WIDTH    = 7;
  localparam int REG_WIDTH       = 8;
  localparam int DATA_WIDTH      = 8;

  localparam logic [RT_WIDTH-1:0]     RESPONSE_TIME_RST = 32'd48000;
  localparam logic [DATA_WIDTH-1:0]   POLY_RST          = 8'b0000_0111;
  localparam logic [DATA_WIDTH-1:0]   FIXED_POLY        = 8'b0000_0111;
  localparam logic [DATA_WIDTH-1:0]   CRC_MSB_MASK      = 8'h80;
  localparam logic [TARGET_WIDTH-1:0] TARGET_RST        = 7'h69;
  localparam logic [REG_WIDTH-1:0]    QUESTION_REG_RST  = 8'h17;
  localparam logic [REG_WIDTH-1:0]    ANSWER_REG_RST    = 8'h18;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_RESPONSE_TIME = 3'd0,
    CFG_SERVICE_EN    = 3'd1,
    CFG_ANSWER_MODE   = 3'd2,
    CFG_ANSWER_POLY   = 3'd3,
    CFG_TARGET_ADDR   = 3'd4,
    CFG_QUESTION_REG  = 3'd5,
    CFG_ANSWER_REG    = 3'd6,
    CFG_PEC_EN        = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    REQ_TICK     = 1'b0,
    REQ_QUESTION = 1'b1
  } req_type_t;

  typedef enum logic {
    BUS_OP_READ  = 1'b0,
    BUS_OP_WRITE = 1'b1
  } bus_op_t;

  typedef enum logic {
    MODE_FIXED = 1'b0,
    MODE_POLY  = 1'b1
  } answer_mode_t;

  typedef struct packed {
    logic [RT_WIDTH-1:0]     response_time_us;
    logic                    service_enable;
    logic                    answer_mode;
    logic [DATA_WIDTH-1:0]   answer_polynomial;
    logic [TARGET_WIDTH-1:0] target_address;
    logic [REG_WIDTH-1:0]    question_register;
    logic [REG_WIDTH-1:0]    answer_register;
    logic                    pec_enable;
  } cfg_t;

endpackage

[rtl/core/qaws_in_if.sv]
// Input channel of the watchdog servicer: ticks and question bytes.
interface qaws_in_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic                              power_good;
  logic [qaws_pkg::DATA_WIDTH-1:0]   question_byte;

  modport source (output valid, output req_type, output power_good,
                  output question_byte, input ready);
  modport sink (input valid, input req_type, input power_good,
                input question_byte, output ready);
endinterface

[rtl/core/qaws_out_if.sv]
// Result channel of the watchdog servicer: bus transfer requests.
interface qaws_out_if;
  logic                              valid;
  logic                              ready;
  logic                              bus_op;
  logic [qaws_pkg::TARGET_WIDTH-1:0] bus_target;
  logic [qaws_pkg::REG_WIDTH-1:0]    bus_register;
  logic                              bus_pec;
  logic [qaws_pkg::DATA_WIDTH-1:0]   bus_data;

  modport source (output valid, output bus_op, output bus_target,
                  output bus_register, output bus_pec, output bus_data, input ready);
  modport sink (input valid, input bus_op, input bus_target,
                input bus_register, input bus_pec, input bus_data, output ready);
endinterface

[rtl/core/qaws_cfg_regs.sv]
// Configuration register file of the watchdog servicer.
module qaws_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [qaws_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [qaws_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata,
  output qaws_pkg::cfg_t                        cfg
);

  qaws_pkg::cfg_t cfg_r;
  qaws_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (qaws_pkg::cfg_idx_t'(cfg_index))
        qaws_pkg::CFG_RESPONSE_TIME:
          cfg_nxt.response_time_us = cfg_wdata[qaws_pkg::RT_WIDTH-1:0];
        qaws_pkg::CFG_SERVICE_EN:   cfg_nxt.service_enable = cfg_wdata[0];
        qaws_pkg::CFG_ANSWER_MODE:  cfg_nxt.answer_mode    = cfg_wdata[0];
        qaws_pkg::CFG_ANSWER_POLY:
          cfg_nxt.answer_polynomial = cfg_wdata[qaws_pkg::DATA_WIDTH-1:0];
        qaws_pkg::CFG_TARGET_ADDR:
          cfg_nxt.target_address = cfg_wdata[qaws_pkg::TARGET_WIDTH-1:0];
        qaws_pkg::CFG_QUESTION_REG:
          cfg_nxt.question_register = cfg_wdata[qaws_pkg::REG_WIDTH-1:0];
        qaws_pkg::CFG_ANSWER_REG:
          cfg_nxt.answer_register = cfg_wdata[qaws_pkg::REG_WIDTH-1:0];
        qaws_pkg::CFG_PEC_EN:       cfg_nxt.pec_enable     = cfg_wdata[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.response_time_us  <= qaws_pkg::RESPONSE_TIME_RST;
      cfg_r.service_enable    <= 1'b0;
      cfg_r.answer_mode       <= qaws_pkg::MODE_FIXED;
      cfg_r.answer_polynomial <= qaws_pkg::POLY_RST;
      cfg_r.target_address    <= qaws_pkg::TARGET_RST;
      cfg_r.question_register <= qaws_pkg::QUESTION_REG_RST;
      cfg_r.answer_register   <= qaws_pkg::ANSWER_REG_RST;
      cfg_r.pec_enable        <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/qaws_crc8.sv]
// Unrolled MSB-first CRC-8 of one question byte.
module qaws_crc8 (
  input  logic [qaws_pkg::DATA_WIDTH-1:0] question_byte,
  input  logic                            answer_mode,
  input  logic [qaws_pkg::DATA_WIDTH-1:0] answer_polynomial,
  output logic [qaws_pkg::DATA_WIDTH-1:0] answer
);

  logic [qaws_pkg::DATA_WIDTH-1:0] poly;
  logic [qaws_pkg::DATA_WIDTH-1:0] crc;

  // An unknown mode value cannot occur in one bit; anything but fixed mode uses the register.
  assign poly = (answer_mode == qaws_pkg::MODE_FIXED) ? qaws_pkg::FIXED_POLY
                                                      : answer_polynomial;

  always_comb begin
    crc = question_byte;
    for (int i = 0; i < qaws_pkg::DATA_WIDTH; i++) begin
      if ((crc & qaws_pkg::CRC_MSB_MASK) != '0) begin
        crc = {crc[qaws_pkg::DATA_WIDTH-2:0], 1'b0} ^ poly;
      end else begin
        crc = {crc[qaws_pkg::DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign answer = crc;

endmodule

[rtl/core/qaws_core.sv]
// Servicing datapath: input stage, tick counter, wait flag and result register.
`include "assert_macros.svh"

module qaws_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  qaws_pkg::cfg_t                     cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic                               in_power_good,
  input  logic [qaws_pkg::DATA_WIDTH-1:0]    in_question_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_bus_op,
  output logic [qaws_pkg::TARGET_WIDTH-1:0]  out_bus_target,
  output logic [qaws_pkg::REG_WIDTH-1:0]     out_bus_register,
  output logic                               out_bus_pec,
  output logic [qaws_pkg::DATA_WIDTH-1:0]    out_bus_data
);

  localparam int CntW = qaws_pkg::COUNT_WIDTH;
  localparam int CmpW = qaws_pkg::CMP_WIDTH;
  localparam int DatW = qaws_pkg::DATA_WIDTH;

  // Input stage.
  logic            s1_valid_r, s1_valid_nxt;
  logic            s1_req_r;
  logic            s1_pg_r;
  logic [DatW-1:0] s1_q_r;

  // Servicing state.
  logic [CntW-1:0] count_r, count_nxt;
  logic            await_r, await_nxt;

  // Result register.
  logic                              out_valid_r, out_valid_nxt;
  logic                              op_r;
  logic [qaws_pkg::TARGET_WIDTH-1:0] target_r;
  logic [qaws_pkg::REG_WIDTH-1:0]    reg_r;
  logic                              pec_r;
  logic [DatW-1:0]                   data_r;

  logic            res_valid;
  logic            res_op;
  logic [DatW-1:0] res_data;
  logic [DatW-1:0] answer;
  logic [CntW-1:0] count_inc;
  logic            s1_adv;
  logic            load;
  logic            in_fire;

  qaws_crc8 u_crc8 (
    .question_byte     (s1_q_r),
    .answer_mode       (cfg.answer_mode),
    .answer_polynomial (cfg.answer_polynomial),
    .answer            (answer)
  );

  assign count_inc = (&count_r) ? count_r : count_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    await_nxt = await_r;
    res_valid = 1'b0;
    res_op    = qaws_pkg::BUS_OP_READ;
    res_data  = '0;
    if (s1_valid_r) begin
      if (s1_req_r == qaws_pkg::REQ_TICK) begin
        if (!cfg.service_enable || !s1_pg_r) begin
          count_nxt = '0;
          await_nxt = 1'b0;
        end else if (!await_r) begin
          count_nxt = count_inc;
          if (CmpW'(count_inc) >= CmpW'(cfg.response_time_us)) begin
            await_nxt = 1'b1;
            res_valid = 1'b1;
          end
        end
      end else if (await_r) begin
        count_nxt = '0;
        await_nxt = 1'b0;
        res_valid = 1'b1;
        res_op    = qaws_pkg::BUS_OP_WRITE;
        res_data  = answer;
      end
    end
  end

  // The input stage moves on unless it holds a result that cannot enter the result register.
  assign s1_adv   = !res_valid || !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign load     = s1_valid_r && res_valid && s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      count_r     <= '0;
      await_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_valid_r && s1_adv) begin
        count_r <= count_nxt;
        await_r <= await_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r <= in_req_type;
      s1_pg_r  <= in_power_good;
      s1_q_r   <= in_question_byte;
    end
    if (load) begin
      op_r     <= res_op;
      target_r <= cfg.target_address;
      reg_r    <= (res_op == qaws_pkg::BUS_OP_WRITE) ? cfg.answer_register
                                                     : cfg.question_register;
      pec_r    <= cfg.pec_enable;
      data_r   <= res_data;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bus_op       = op_r;
  assign out_bus_target   = target_r;
  assign out_bus_register = reg_r;
  assign out_bus_pec      = pec_r;
  assign out_bus_data     = data_r;

  `QAWS_ASSERT(a_read_starts_wait, clk, rst_n, (load && res_op == qaws_pkg::BUS_OP_READ) |=> await_r, "read issued without entering wait")
  `QAWS_ASSERT(a_write_clears, clk, rst_n, (load && res_op == qaws_pkg::BUS_OP_WRITE) |=> (!await_r && count_r == '0), "answer did not clear count and wait")
  `QAWS_ASSERT(a_wait_freezes, clk, rst_n, (await_r && $past(await_r)) |-> (count_r == $past(count_r)), "count moved while waiting")
  `QAWS_ASSERT(a_stage_kept, clk, rst_n, (s1_valid_r && !s1_adv) |=> s1_valid_r, "held item dropped from input stage")

endmodule

[rtl/core/qa_watchdog_servicer.sv]
// Top level of the question-and-answer watchdog servicer.
//
// The input channel carries items of two kinds: a one-microsecond tick with
// the power-good level sampled alongside, and a question byte that a bus read
// returned. While servicing is enabled and power-good is high, ticks advance a
// saturating count; otherwise the count clears and any wait is dropped.
// When the count reaches the response time, a bus read of the question
// register is issued on the result channel and ticks stop counting until the
// question arrives. A question received while waiting is answered with its
// CRC-8 in a bus write to the answer register, and the count restarts.
// The user must write configuration through the cfg_ port only while the
// block is idle; the block itself does not enforce this.
// An accepted item is registered in the input stage, and its result, if any,
// in the result register. One item is accepted per clock cycle while ready
// is high; the counter update and unrolled CRC between the input stage and
// the result register are combinational. When the receiver stalls, the
// result register holds its item and the input stage keeps taking items;
// ready drops only when the item it holds also has a result waiting.
// Synchronous reset clears both stages, the count and the wait flag, and
// restores every configuration register to its default.
module qa_watchdog_servicer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  qaws_in_if.sink                              in_ch,
  qaws_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [qaws_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [qaws_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

  // Current register settings, shared with the datapath as one bundle.
  qaws_pkg::cfg_t cfg;

  qaws_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Counter, wait flag, CRC and result register.
  qaws_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_req_type      (in_ch.req_type),
    .in_power_good    (in_ch.power_good),
    .in_question_byte (in_ch.question_byte),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_bus_op       (out_ch.bus_op),
    .out_bus_target   (out_ch.bus_target),
    .out_bus_register (out_ch.bus_register),
    .out_bus_pec      (out_ch.bus_pec),
    .out_bus_data     (out_ch.bus_data)
  );

endmodule
